// ----- hw/rtl/lse_pkg.sv -----
`default_nettype none
package lse_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int FILL_W      = 9;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [FILL_W-1:0]   fill_t;

  localparam op_t OP_PUSH  = 3'd0;
  localparam op_t OP_POP   = 3'd1;
  localparam op_t OP_PEEK  = 3'd2;
  localparam op_t OP_DUP   = 3'd3;
  localparam op_t OP_SWAP  = 3'd4;
  localparam op_t OP_CLEAR = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_OVER  = 2'd1;
  localparam status_t ST_UNDER = 2'd2;

  // one write port request into the stack memory
  typedef struct packed {
    logic  we;
    addr_t addr;
    word_t data;
  } ram_wr_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lse_in_if.sv -----
`default_nettype none
interface lse_in_if;
  import lse_pkg::*;

  logic  valid;
  logic  ready;
  op_t   op;
  word_t push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lse_out_if.sv -----
`default_nettype none
interface lse_out_if;
  import lse_pkg::*;

  logic    valid;
  logic    ready;
  word_t   result_value;
  status_t status;
  logic    is_empty;
  fill_t   fill_count;

  modport source (output valid, output result_value, output status, output is_empty,
                  output fill_count, input ready);
  modport sink   (input valid, input result_value, input status, input is_empty,
                  input fill_count, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lse_ram.sv -----
`default_nettype none
module lse_ram (
  input  wire logic            clk,
  input  wire lse_pkg::ram_wr_t wr,
  input  wire logic            re,
  input  wire lse_pkg::addr_t  raddr_a,
  input  wire lse_pkg::addr_t  raddr_b,
  output lse_pkg::word_t       rdata_a,
  output lse_pkg::word_t       rdata_b
);
  import lse_pkg::*;

  word_t mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lifo_stack_engine_unit.sv -----
`default_nettype none
// channel   dir   handshake      words carried
// in_ch     in    valid/ready    op, push_value
// out_ch    out   valid/ready    result_value, status, is_empty, fill_count
//
// a word is taken only while the sequencer is idle; the top two entries are read
// at that edge and the result is registered from execute once the output is free, swap included
// no new word is taken until the last is done; swap adds a second write state (single write port)
// a stalled output holds the sequencer in execute, so no new word is taken
// reset empties the stack (count to zero); memory contents are not cleared
module lifo_stack_engine_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  lse_in_if.sink    in_ch,
  lse_out_if.source out_ch
);
  import lse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_SWAP2 = 3'b100
  } state_t;

  state_t  state_r, state_nxt;
  cnt_t    cnt_r, cnt_nxt;
  op_t     op_r;
  word_t   val_r;
  word_t   rd_a, rd_b;      // top entry and the one below it
  ram_wr_t wr;

  logic    out_valid_r, out_valid_nxt;
  word_t   res_value_r, res_value_nxt;
  status_t res_status_r, res_status_nxt;
  cnt_t    res_cnt_r;

  logic    accept;
  logic    out_free;
  logic    full, empty;
  addr_t   top_addr, sec_addr, push_addr;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign full     = (cnt_r == CNT_W'(STACK_DEPTH));
  assign empty    = (cnt_r == '0);

  // address arithmetic on the count, truncated to the memory index
  logic [CNT_W-1:0] cnt_m1, cnt_m2;
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign cnt_m2    = cnt_r - CNT_W'(2);
  assign top_addr  = cnt_m1[ADDR_W-1:0];
  assign sec_addr  = cnt_m2[ADDR_W-1:0];
  assign push_addr = cnt_r[ADDR_W-1:0];

  assign in_ch.ready = (state_r == S_IDLE);

  lse_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .re      (accept),
    .raddr_a (top_addr),
    .raddr_b (sec_addr),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // operation decode, memory write and next count
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    wr             = '0;
    res_value_nxt  = '0;
    res_status_nxt = ST_OK;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          case (op_r)
            OP_PUSH: begin
              if (full) begin
                res_status_nxt = ST_OVER;
              end else begin
                wr      = '{we: 1'b1, addr: push_addr, data: val_r};
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (empty) begin
                res_status_nxt = ST_UNDER;
              end else begin
                res_value_nxt = rd_a;
                cnt_nxt       = cnt_m1;
              end
            end
            OP_PEEK: begin
              if (empty) begin
                res_status_nxt = ST_UNDER;
              end else begin
                res_value_nxt = rd_a;
              end
            end
            OP_DUP: begin
              if (empty) begin
                res_status_nxt = ST_UNDER;
              end else if (full) begin
                res_status_nxt = ST_OVER;
              end else begin
                wr      = '{we: 1'b1, addr: push_addr, data: rd_a};
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            OP_SWAP: begin
              if (cnt_r < CNT_W'(2)) begin
                res_status_nxt = ST_UNDER;
              end else begin
                wr        = '{we: 1'b1, addr: top_addr, data: rd_b};
                state_nxt = S_SWAP2;
              end
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              // unused codes leave the stack alone
            end
          endcase
        end
      end
      S_SWAP2: begin
        // old top goes one below
        wr        = '{we: 1'b1, addr: sec_addr, data: rd_a};
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_ch.op;
      val_r <= in_ch.push_value;
    end
    if (state_r == S_EXEC && out_free) begin
      res_value_r  <= res_value_nxt;
      res_status_r <= res_status_nxt;
      res_cnt_r    <= cnt_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = res_value_r;
  assign out_ch.status       = res_status_r;
  assign out_ch.is_empty     = (res_cnt_r == '0);
  assign out_ch.fill_count   = FILL_W'(res_cnt_r);

  // count stays within the memory depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // an accepted word always moves straight to execution
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted word not executed");

  // memory is never written while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr.we |-> state_r != S_IDLE)
    else $error("stack memory written while idle");

  // a held result does not change under stall
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(res_value_r)
      && $stable(res_cnt_r))
    else $error("held result changed");

endmodule
`default_nettype wire

// ----- verif/lse_result_checker.sv -----
module lse_result_checker (
  input  logic clk,
  input  logic rst_n,
  lse_in_if    in_ch,
  lse_out_if   out_ch,
  output int   err_count,
  output int   pending,
  output int   words_taken,
  output int   results_seen,
  output int   overflow_refused,
  output int   underflow_refused,
  output int   deepest_fill
);
  timeunit 1ns;
  timeprecision 1ps;
  import lse_pkg::*;

  typedef struct packed {
    word_t   value;
    status_t status;
    logic    is_empty;
    fill_t   fill;
  } stack_reply_t;

  // private copy of the stack
  word_t        stack_mem [STACK_DEPTH];
  int           depth;
  stack_reply_t reply_q [$];

  function automatic stack_reply_t apply_op(input op_t op, input word_t val);
    stack_reply_t r;
    word_t        t;
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (depth >= STACK_DEPTH) begin
          r.status = ST_OVER;
        end else begin
          stack_mem[depth] = val;
          depth++;
        end
      end
      OP_POP: begin
        if (depth == 0) begin
          r.status = ST_UNDER;
        end else begin
          depth--;
          r.value = stack_mem[depth];
        end
      end
      OP_PEEK: begin
        if (depth == 0) r.status = ST_UNDER;
        else r.value = stack_mem[depth-1];
      end
      OP_DUP: begin
        if (depth == 0) begin
          r.status = ST_UNDER;
        end else if (depth >= STACK_DEPTH) begin
          r.status = ST_OVER;
        end else begin
          stack_mem[depth] = stack_mem[depth-1];
          depth++;
        end
      end
      OP_SWAP: begin
        if (depth < 2) begin
          r.status = ST_UNDER;
        end else begin
          t                  = stack_mem[depth-1];
          stack_mem[depth-1] = stack_mem[depth-2];
          stack_mem[depth-2] = t;
        end
      end
      OP_CLEAR: depth = 0;
      default: ;
    endcase
    r.is_empty = (depth == 0);
    r.fill     = fill_t'(depth);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("t=%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    stack_reply_t want;
    if (!rst_n) begin
      depth = 0;
      reply_q.delete();
    end else begin
      // word taken: predict its reply straight away
      if (in_ch.valid && in_ch.ready) begin
        want = apply_op(in_ch.op, in_ch.push_value);
        reply_q.push_back(want);
        words_taken++;
        if (want.status == ST_OVER) overflow_refused++;
        if (want.status == ST_UNDER) underflow_refused++;
        if (depth > deepest_fill) deepest_fill = depth;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (reply_q.size() == 0) begin
          err_count++;
          $display("t=%0t unexpected result: expected nothing, actual %h/%0d/%0d/%0d",
                   $time, out_ch.result_value, out_ch.status, out_ch.is_empty,
                   out_ch.fill_count);
        end else begin
          want = reply_q.pop_front();
          check_field("result_value", want.value, out_ch.result_value);
          check_field("status", want.status, out_ch.status);
          check_field("is_empty", want.is_empty, out_ch.is_empty);
          check_field("fill_count", want.fill, out_ch.fill_count);
        end
      end
    end
    pending = reply_q.size();
  end

endmodule

// ----- verif/tb_lifo_stack_engine_unit.sv -----
module tb_lifo_stack_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lse_pkg::*;

  // op codes the block leaves unused; they must still give a plain reply
  localparam op_t OP_SPARE6 = 3'd6;
  localparam op_t OP_SPARE7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  // chance in a hundred, per cycle, that the sender idles / the receiver stalls
  int src_idle_pct;
  int sink_stall_pct;

  int err_count, pending, words_taken, results_seen;
  int overflow_refused, underflow_refused, deepest_fill;

  lse_in_if  in_ch ();
  lse_out_if out_ch ();

  lifo_stack_engine_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // watches both channels, predicts every reply and counts mismatches
  lse_result_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .err_count         (err_count),
    .pending           (pending),
    .words_taken       (words_taken),
    .results_seen      (results_seen),
    .overflow_refused  (overflow_refused),
    .underflow_refused (underflow_refused),
    .deepest_fill      (deepest_fill)
  );

  always #5 clk = ~clk;

  // receiver back-pressure, redrawn every cycle on the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // mostly random words, with the odd float corner pattern mixed in
  function automatic word_t pick_word();
    case ($urandom_range(15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;   // negative zero
      3:       return 32'h7F80_0000;   // infinity
      4:       return 32'h7FC0_0001;   // nan with payload
      default: return word_t'($urandom);
    endcase
  endfunction

  // push leads so the stack drifts upwards between clears
  function automatic op_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 34) return OP_PUSH;
    else if (r < 58) return OP_POP;
    else if (r < 68) return OP_PEEK;
    else if (r < 78) return OP_DUP;
    else if (r < 90) return OP_SWAP;
    else if (r < 96) return OP_CLEAR;
    else if (r < 98) return OP_SPARE6;
    else return OP_SPARE7;
  endfunction

  // called on a falling edge, returns on the falling edge after the word is taken;
  // valid stays high across back-to-back words
  task automatic send_word(input op_t op, input word_t val);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.push_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender off until every reply has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // random mix under one idle/stall setting, with a full drain half way
  task automatic run_random(input int n, input int idle, input int stall);
    src_idle_pct   = idle;
    sink_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_drained();
      send_word(pick_op(), pick_word());
    end
  endtask

  // clear, fill to the brim, knock on the full stack, then empty it again
  task automatic fill_and_drain();
    int fill;
    int r;
    send_word(OP_CLEAR, pick_word());
    send_word(OP_PUSH, pick_word());
    fill = 1;
    while (fill < STACK_DEPTH) begin
      r = $urandom_range(99);
      if (r < 20) begin
        send_word(OP_DUP, pick_word());
        fill++;
      end else if (r < 28) begin
        send_word(OP_SWAP, pick_word());
      end else if (r < 32) begin
        send_word(OP_PEEK, pick_word());
      end else begin
        send_word(OP_PUSH, pick_word());
        fill++;
      end
    end
    // full: push and dup are refused, swap and peek still work
    send_word(OP_PUSH, pick_word());
    send_word(OP_DUP, pick_word());
    send_word(OP_SWAP, pick_word());
    send_word(OP_PEEK, pick_word());
    send_word(OP_PUSH, pick_word());
    while (fill > 0) begin
      r = $urandom_range(99);
      if (r < 80) begin
        send_word(OP_POP, pick_word());
        fill--;
      end else if (r < 90) begin
        send_word(OP_PEEK, pick_word());
      end else begin
        send_word(OP_SWAP, pick_word());
      end
    end
    send_word(OP_POP, pick_word());
    send_word(OP_PEEK, pick_word());
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_PUSH;
    in_ch.push_value = '0;
    out_ch.ready     = 1'b0;
    rst_n            = 1'b0;
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners from a freshly emptied stack
    send_word(OP_POP, pick_word());        // pop on empty
    send_word(OP_PEEK, pick_word());       // peek on empty
    send_word(OP_DUP, pick_word());        // dup on empty
    send_word(OP_SWAP, pick_word());       // swap on empty
    send_word(OP_SPARE6, 32'hFFFF_FFFF);   // unused code while empty
    send_word(OP_PUSH, 32'h0000_0000);
    send_word(OP_SWAP, pick_word());       // swap with a single entry
    send_word(OP_PUSH, 32'hFFFF_FFFF);
    send_word(OP_SWAP, pick_word());
    send_word(OP_PEEK, pick_word());
    send_word(OP_DUP, pick_word());
    send_word(OP_PUSH, 32'h7F80_0000);
    send_word(OP_PUSH, 32'h8000_0000);
    send_word(OP_SPARE7, 32'h0000_0000);   // unused code with entries held
    send_word(OP_POP, pick_word());
    send_word(OP_POP, pick_word());
    send_word(OP_CLEAR, pick_word());      // clear with entries held
    send_word(OP_CLEAR, pick_word());      // clear when already empty
    send_word(OP_PUSH, 32'h7FC0_0000);
    send_word(OP_POP, pick_word());
    send_word(OP_POP, pick_word());

    // idle/stall phases: none, sender only, receiver only, both
    run_random(200, 0, 0);
    run_random(200, 48, 0);
    src_idle_pct   = 0;
    sink_stall_pct = 48;
    fill_and_drain();
    run_random(200, 10, 10);

    // let the last replies through, then keep watching a quiet bus for strays
    wait_drained();
    repeat (8) @(negedge clk);

    $display("run covered %0d words and %0d replies, stack fill peaked at %0d of %0d",
             words_taken, results_seen, deepest_fill, STACK_DEPTH);
    $display("refused: %0d overflow, %0d underflow, across four idle and stall mixes",
             overflow_refused, underflow_refused);
    if (err_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
